// ===== src/ehb_pkg.sv =====
package ehb_pkg;

   typedef enum logic [1:0] {
      ACT_SEARCH = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_SPLIT  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      RS_OK     = 2'd0,
      RS_ABSENT = 2'd1,
      RS_FULL   = 2'd2,
      RS_LIMIT  = 2'd3
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FIN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic depth_inc;
      logic rd;
      logic idx_inc;
      logic w_inc;
      logic wr_keep;
      logic found_set;
      logic append;
      logic fill_from_w;
      logic pass2;
      logic emit_moved;
      logic emit_resp;
   } cmd_type;

   typedef struct packed {
      action_type act;
      logic       rej_now;
      logic       scan_done;
      logic       match;
      logic       keep;
      logic       found;
      logic       pass2;
      logic       no_move;
      logic       out_free;
   } stat_type;

endpackage

// ===== src/extendible_hash_bucket.sv =====
// Channel   Direction  Handshake             Beat
// req_      in         req_valid/req_stall   action, key, value
// rsp_      out        rsp_valid/rsp_stall   status, counts, moved entry, last, fill, depth
// csr_      in         csr_wr_en             bucket id, written at once
//
// One item at a time. Each scan step reads one entry from the single-port entry memory
// and evaluates it in the next cycle. A split that moves entries scans the bucket twice.
// Search, insert and delete scan once. Inserts into a full bucket and splits at the
// depth limit are rejected without a scan.
// Reset is synchronous: the bucket is empty with local depth one and bucket id zero.
// A stalled result holds the block; no item is taken before the last beat is registered.
module extendible_hash_bucket
   import ehb_pkg::*;
#(
   parameter int BUCKET_SIZE = 8,
   parameter int KEY_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_removed_count,
   output logic        rsp_moved_valid,
   output logic [31:0] rsp_moved_key,
   output logic [31:0] rsp_moved_value,
   output logic        rsp_last,
   output logic [3:0]  rsp_fill_now,
   output logic [5:0]  rsp_depth_now,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   cmd_type    cmd;
   stat_type   stat;
   action_type action;

   assign action = action_type'(req_action);

   ehb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   ehb_datapath #(
      .BUCKET_SIZE (BUCKET_SIZE),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (action),
      .req_key           (req_key),
      .req_value         (req_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_moved_valid   (rsp_moved_valid),
      .rsp_moved_key     (rsp_moved_key),
      .rsp_moved_value   (rsp_moved_value),
      .rsp_last          (rsp_last),
      .rsp_fill_now      (rsp_fill_now),
      .rsp_depth_now     (rsp_depth_now)
   );

endmodule

// ===== src/ehb_datapath.sv =====
module ehb_datapath
   import ehb_pkg::*;
#(
   parameter int BUCKET_SIZE = 8,
   parameter int KEY_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  action_type  req_action,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_removed_count,
   output logic        rsp_moved_valid,
   output logic [31:0] rsp_moved_key,
   output logic [31:0] rsp_moved_value,
   output logic        rsp_last,
   output logic [3:0]  rsp_fill_now,
   output logic [5:0]  rsp_depth_now
);

   localparam int CW = $clog2(BUCKET_SIZE + 1);
   localparam int IW = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
   localparam int DW = $clog2(KEY_WIDTH + 1);

   logic [31:0] key_mem [BUCKET_SIZE];
   logic [31:0] val_mem [BUCKET_SIZE];

   action_type  act_ff, act_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] val_ff, val_in;
   logic        rej_ff, rej_in;
   logic        found_ff, found_in;
   logic        pass2_ff, pass2_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] w_ff, w_in;
   logic [CW-1:0] em_ff, em_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [31:0] bid_ff, bid_in;
   logic [31:0] rd_key_ff;
   logic [31:0] rd_val_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [3:0]  removed_ff, removed_in;
   logic        moved_ff, moved_in;
   logic [31:0] mkey_ff, mkey_in;
   logic [31:0] mval_ff, mval_in;
   logic        last_ff, last_in;
   logic [3:0]  fillo_ff, fillo_in;
   logic [5:0]  deptho_ff, deptho_in;

   logic [31:0] mask;
   logic [6:0]  depth_wide;
   logic        full;
   logic        at_limit;
   logic        out_free;
   logic [CW:0] emit_sum;
   logic [CW-1:0] removed;
   result_type  resp_code;

   assign depth_wide = 7'(depth_ff);
   assign full       = (fill_ff == CW'(BUCKET_SIZE));
   assign at_limit   = (depth_wide >= 7'(KEY_WIDTH));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign removed    = n_ff - w_ff;
   assign emit_sum   = (CW + 1)'(em_ff) + (CW + 1)'(fill_ff) + (CW + 1)'(1);

   always_comb begin
      for (int b = 0; b < 32; b++) begin
         mask[b] = (depth_wide > 7'(b));
      end
   end

   always_comb begin
      if (rej_ff) begin
         resp_code = (act_ff == ACT_INSERT) ? RS_FULL : RS_LIMIT;
      end else begin
         case (act_ff)
            ACT_SEARCH: resp_code = found_ff ? RS_OK : RS_ABSENT;
            ACT_DELETE: resp_code = (removed != '0) ? RS_OK : RS_ABSENT;
            default:    resp_code = RS_OK;
         endcase
      end
   end

   always_comb begin
      stat.act       = act_ff;
      stat.rej_now   = ((req_action == ACT_INSERT) && full) ||
                       ((req_action == ACT_SPLIT) && at_limit);
      stat.scan_done = (idx_ff == n_ff);
      stat.match     = (rd_key_ff == key_ff);
      stat.keep      = ((rd_key_ff & mask) == bid_ff);
      stat.found     = found_ff;
      stat.pass2     = pass2_ff;
      stat.no_move   = (w_ff == n_ff);
      stat.out_free  = out_free;
   end

   always_comb begin
      act_in   = act_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      rej_in   = rej_ff;
      found_in = found_ff;
      pass2_in = pass2_ff;
      n_in     = n_ff;
      idx_in   = idx_ff;
      w_in     = w_ff;
      em_in    = em_ff;
      fill_in  = fill_ff;
      depth_in = depth_ff;
      bid_in   = csr_wr_en ? csr_wr_data : bid_ff;

      if (cmd.start) begin
         act_in   = req_action;
         key_in   = req_key;
         val_in   = req_value;
         rej_in   = stat.rej_now;
         found_in = 1'b0;
         pass2_in = 1'b0;
         n_in     = fill_ff;
         idx_in   = '0;
         w_in     = '0;
         em_in    = '0;
      end
      if (cmd.depth_inc) begin
         depth_in = depth_ff + DW'(1);
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.w_inc) begin
         w_in = w_ff + CW'(1);
      end
      if (cmd.found_set) begin
         found_in = 1'b1;
      end
      if (cmd.append) begin
         fill_in = fill_ff + CW'(1);
      end
      if (cmd.fill_from_w) begin
         fill_in = w_ff;
      end
      if (cmd.emit_moved) begin
         em_in = em_ff + CW'(1);
      end
      if (cmd.pass2) begin
         pass2_in = 1'b1;
         idx_in   = '0;
         w_in     = '0;
         em_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      removed_in   = removed_ff;
      moved_in     = moved_ff;
      mkey_in      = mkey_ff;
      mval_in      = mval_ff;
      last_in      = last_ff;
      fillo_in     = fillo_ff;
      deptho_in    = deptho_ff;
      if (cmd.emit_moved) begin
         rsp_valid_in = 1'b1;
         status_in    = RS_OK;
         removed_in   = '0;
         moved_in     = 1'b1;
         mkey_in      = rd_key_ff;
         mval_in      = rd_val_ff;
         last_in      = (emit_sum == (CW + 1)'(n_ff));
         fillo_in     = 4'(fill_ff);
         deptho_in    = 6'(depth_ff);
      end else if (cmd.emit_resp) begin
         rsp_valid_in = 1'b1;
         status_in    = resp_code;
         removed_in   = (!rej_ff && (act_ff == ACT_DELETE)) ? 4'(removed) : 4'd0;
         moved_in     = 1'b0;
         mkey_in      = '0;
         mval_in      = '0;
         last_in      = 1'b1;
         fillo_in     = 4'(fill_ff);
         deptho_in    = 6'(depth_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         depth_ff     <= DW'(1);
         bid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         pass2_ff     <= 1'b0;
         rej_ff       <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         depth_ff     <= depth_in;
         bid_ff       <= bid_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         pass2_ff     <= pass2_in;
         rej_ff       <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      w_ff      <= w_in;
      em_ff     <= em_in;
      status_ff <= status_in;
      removed_ff <= removed_in;
      moved_ff  <= moved_in;
      mkey_ff   <= mkey_in;
      mval_ff   <= mval_in;
      last_ff   <= last_in;
      fillo_ff  <= fillo_in;
      deptho_ff <= deptho_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_keep) begin
         key_mem[w_ff[IW-1:0]] <= rd_key_ff;
         val_mem[w_ff[IW-1:0]] <= rd_val_ff;
      end else if (cmd.append) begin
         key_mem[fill_ff[IW-1:0]] <= key_ff;
         val_mem[fill_ff[IW-1:0]] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_key_ff <= key_mem[idx_ff[IW-1:0]];
         rd_val_ff <= val_mem[idx_ff[IW-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_count = removed_ff;
   assign rsp_moved_valid   = moved_ff;
   assign rsp_moved_key     = mkey_ff;
   assign rsp_moved_value   = mval_ff;
   assign rsp_last          = last_ff;
   assign rsp_fill_now      = fillo_ff;
   assign rsp_depth_now     = deptho_ff;

endmodule

// ===== src/ehb_ctrl.sv =====
module ehb_ctrl
   import ehb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (stat.rej_now) begin
                  state_in = S_RESP;
               end else begin
                  cmd.depth_inc = (req_action == ACT_SPLIT);
                  state_in      = S_READ;
               end
            end
         end
         S_READ: begin
            if (stat.scan_done) begin
               state_in = S_FIN;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (stat.act) inside
               ACT_SEARCH, ACT_INSERT: begin
                  cmd.found_set = stat.match;
                  cmd.idx_inc   = 1'b1;
                  state_in      = S_READ;
               end
               ACT_DELETE: begin
                  cmd.wr_keep = !stat.match;
                  cmd.w_inc   = !stat.match;
                  cmd.idx_inc = 1'b1;
                  state_in    = S_READ;
               end
               default: begin
                  if (!stat.pass2) begin
                     cmd.w_inc   = stat.keep;
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end else if (stat.keep) begin
                     cmd.wr_keep = 1'b1;
                     cmd.w_inc   = 1'b1;
                     cmd.idx_inc = 1'b1;
                     state_in    = S_READ;
                  end else if (stat.out_free) begin
                     cmd.emit_moved = 1'b1;
                     cmd.idx_inc    = 1'b1;
                     state_in       = S_READ;
                  end
               end
            endcase
         end
         S_FIN: begin
            unique case (stat.act)
               ACT_SEARCH: begin
                  state_in = S_RESP;
               end
               ACT_INSERT: begin
                  cmd.append = !stat.found;
                  state_in   = S_RESP;
               end
               ACT_DELETE: begin
                  cmd.fill_from_w = 1'b1;
                  state_in        = S_RESP;
               end
               default: begin
                  if (stat.pass2) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.fill_from_w = 1'b1;
                     if (stat.no_move) begin
                        state_in = S_RESP;
                     end else begin
                        cmd.pass2 = 1'b1;
                        state_in  = S_READ;
                     end
                  end
               end
            endcase
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.emit_resp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb
   import ehb_pkg::*;
();

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  removed;
      logic        moved;
      logic [31:0] moved_key;
      logic [31:0] moved_value;
      logic        last;
      logic [3:0]  fill;
      logic [5:0]  depth;
   } bucket_beat_type;

   class bucket_scoreboard;
      logic [31:0]     keys [8];
      logic [31:0]     values [8];
      int unsigned     fill;
      int unsigned     depth;
      logic [31:0]     bucket_id;
      bucket_beat_type pending_beats [$];
      int unsigned     errors;

      function new();
         fill = 0;
         depth = 1;
         bucket_id = '0;
         errors = 0;
      endfunction

      function bit holds(logic [31:0] key);
         for (int i = 0; i < fill; i++) begin
            if (keys[i] == key) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void push(logic [1:0] status, logic [3:0] removed, logic moved,
                         logic [31:0] mkey, logic [31:0] mvalue, logic last);
         bucket_beat_type beat;
         beat.status = status;
         beat.removed = removed;
         beat.moved = moved;
         beat.moved_key = mkey;
         beat.moved_value = mvalue;
         beat.last = last;
         beat.fill = fill[3:0];
         beat.depth = depth[5:0];
         pending_beats.push_back(beat);
      endfunction

      function void apply_request(logic [1:0] act, logic [31:0] key, logic [31:0] value);
         logic [31:0] out_keys [8];
         logic [31:0] out_values [8];
         logic [63:0] mask;
         int unsigned kept;
         int unsigned moved;
         int unsigned held;
         case (act)
            ACT_SEARCH: begin
               push(holds(key) ? RS_OK : RS_ABSENT, 0, 0, 0, 0, 1);
            end
            ACT_INSERT: begin
               if (fill >= 8) begin
                  push(RS_FULL, 0, 0, 0, 0, 1);
               end else begin
                  if (!holds(key)) begin
                     keys[fill] = key;
                     values[fill] = value;
                     fill++;
                  end
                  push(RS_OK, 0, 0, 0, 0, 1);
               end
            end
            ACT_DELETE: begin
               held = fill;
               kept = 0;
               for (int i = 0; i < held; i++) begin
                  if (keys[i] != key) begin
                     keys[kept] = keys[i];
                     values[kept] = values[i];
                     kept++;
                  end
               end
               fill = kept;
               push((held != kept) ? RS_OK : RS_ABSENT, 4'(held - kept), 0, 0, 0, 1);
            end
            ACT_SPLIT: begin
               if (depth >= 32) begin
                  push(RS_LIMIT, 0, 0, 0, 0, 1);
               end else begin
                  depth++;
                  mask = (64'h1 << depth) - 1;
                  held = fill;
                  kept = 0;
                  moved = 0;
                  for (int i = 0; i < held; i++) begin
                     if (({32'h0, keys[i]} & mask) == {32'h0, bucket_id}) begin
                        keys[kept] = keys[i];
                        values[kept] = values[i];
                        kept++;
                     end else begin
                        out_keys[moved] = keys[i];
                        out_values[moved] = values[i];
                        moved++;
                     end
                  end
                  fill = kept;
                  if (moved == 0) begin
                     push(RS_OK, 0, 0, 0, 0, 1);
                  end else begin
                     for (int i = 0; i < moved; i++) begin
                        push(RS_OK, 0, 1, out_keys[i], out_values[i], i == moved - 1);
                     end
                  end
               end
            end
            default: begin
               $error("request action is unknown: %b", act);
               errors++;
            end
         endcase
      endfunction

      function void check_response(bucket_beat_type got);
         bucket_beat_type want;
         if (pending_beats.size() == 0) begin
            $error("result beat with nothing expected: status %0d", got.status);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.removed !== want.removed) begin
            $error("removed_count: expected %0d, actual %0d", want.removed, got.removed);
            errors++;
         end
         if (got.moved !== want.moved) begin
            $error("moved_valid: expected %0d, actual %0d", want.moved, got.moved);
            errors++;
         end
         if (got.moved_key !== want.moved_key) begin
            $error("moved_key: expected %h, actual %h", want.moved_key, got.moved_key);
            errors++;
         end
         if (got.moved_value !== want.moved_value) begin
            $error("moved_value: expected %h, actual %h", want.moved_value, got.moved_value);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
         if (got.fill !== want.fill) begin
            $error("fill_now: expected %0d, actual %0d", want.fill, got.fill);
            errors++;
         end
         if (got.depth !== want.depth) begin
            $error("depth_now: expected %0d, actual %0d", want.depth, got.depth);
            errors++;
         end
      endfunction
   endclass

   localparam int unsigned QUIET_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_removed_count;
   logic        rsp_moved_valid;
   logic [31:0] rsp_moved_key;
   logic [31:0] rsp_moved_value;
   logic        rsp_last;
   logic [3:0]  rsp_fill_now;
   logic [5:0]  rsp_depth_now;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   bucket_scoreboard sb;
   bucket_beat_type  seen_beat;
   int unsigned      send_idle_pct;
   int unsigned      stall_pct;
   int unsigned      quiet_cycles;
   int unsigned      phase_send_idle [4] = '{0, 75, 0, 25};
   int unsigned      phase_stall [4] = '{0, 0, 75, 25};

   extendible_hash_bucket DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_moved_valid   (rsp_moved_valid),
      .rsp_moved_key     (rsp_moved_key),
      .rsp_moved_value   (rsp_moved_value),
      .rsp_last          (rsp_last),
      .rsp_fill_now      (rsp_fill_now),
      .rsp_depth_now     (rsp_depth_now),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.apply_request(req_action, req_key, req_value);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_beat.status = rsp_status;
         seen_beat.removed = rsp_removed_count;
         seen_beat.moved = rsp_moved_valid;
         seen_beat.moved_key = rsp_moved_key;
         seen_beat.moved_value = rsp_moved_value;
         seen_beat.last = rsp_last;
         seen_beat.fill = rsp_fill_now;
         seen_beat.depth = rsp_depth_now;
         sb.check_response(seen_beat);
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb NOT OK");
      $finish;
   end

   task automatic wait_slot();
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic offer(logic [1:0] act, logic [31:0] key, logic [31:0] value);
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= key;
      req_value <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic send(logic [1:0] act, logic [31:0] key, logic [31:0] value);
      wait_slot();
      offer(act, key, value);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bucket_id(logic [31:0] id);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= id;
      sb.bucket_id = id;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] staying_key();
      logic [63:0] low;
      low = (64'h1 << (sb.depth + 1)) - 1;
      return ($urandom & ~low[31:0]) | (sb.bucket_id & low[31:0]);
   endfunction

   function automatic logic [31:0] pick_key();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40 && sb.fill != 0) return sb.keys[$urandom_range(0, sb.fill - 1)];
      if (roll < 70) return staying_key();
      return $urandom;
   endfunction

   task automatic send_random();
      int unsigned roll;
      logic [1:0]  act;
      wait_slot();
      roll = $urandom_range(0, 99);
      if (roll < 40) act = ACT_INSERT;
      else if (roll < 55) act = ACT_SEARCH;
      else if (roll < 75) act = ACT_DELETE;
      else act = ACT_SPLIT;
      offer(act, pick_key(), $urandom);
   endtask

   task automatic run_directed();
      logic [31:0] fill_keys [6] = '{32'd4, 32'd8, 32'd1, 32'd2, 32'd3, 32'd16};
      send(ACT_SEARCH, 32'h0, 32'h0);
      send(ACT_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_SPLIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_INSERT, 32'h0, 32'hFFFF_FFFF);
      send(ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
      send(ACT_INSERT, 32'h0, 32'h5);
      send(ACT_SEARCH, 32'hFFFF_FFFF, 32'h0);
      send(ACT_SEARCH, 32'h1, 32'h0);
      foreach (fill_keys[i]) send(ACT_INSERT, fill_keys[i], ~fill_keys[i]);
      send(ACT_INSERT, 32'h7, 32'h7);
      send(ACT_INSERT, 32'h0, 32'h9);
      send(ACT_SPLIT, 32'h0, 32'h0);
      send(ACT_DELETE, 32'h8, 32'h0);
      send(ACT_SPLIT, 32'h1234_5678, 32'h9ABC_DEF0);
      send(ACT_DELETE, 32'h10, 32'h0);
   endtask

   initial begin
      int unsigned splits_left;
      logic [31:0] phase_ids [4];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_SEARCH;
      req_key = '0;
      req_value = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      phase_ids = '{32'h0, 32'hFFFF_FFFF, 32'h5, $urandom};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_send_idle[p];
         stall_pct = phase_stall[p];
         write_bucket_id(phase_ids[p]);
         if (p == 0) run_directed();
         repeat (16) send_random();
         quiesce();
      end

      // Drive the local depth up to the key width, then split past it.
      splits_left = (sb.depth < 32) ? 32 - sb.depth : 0;
      repeat (splits_left) begin
         wait_slot();
         offer(ACT_INSERT, staying_key(), $urandom);
         send(ACT_SPLIT, $urandom, $urandom);
      end
      send(ACT_SPLIT, 32'h0, 32'h0);
      send(ACT_SPLIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      quiesce();
      repeat (40) @(posedge clock);

      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
